/* hdl/arf_pkg.sv */
package arf_pkg;

  // Command codes carried in the command field of an input beat.
  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_STUB   = 2'd1;
  localparam logic [1:0] CMD_DETECT = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // The found-road FIFO has a fixed depth of 256 road numbers.
  localparam int FIFO_AW    = 8;
  localparam int FIFO_DEPTH = 256;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  layer;
    logic [7:0]  road;
    logic [17:0] pattern;
  } arf_in_t;

  typedef struct packed {
    logic        road_valid;
    logic [7:0]  road_out;
    logic [8:0]  roads_found;
    logic        fifo_empty;
    logic        overflow;
  } arf_out_t;

endpackage

/* hdl/associative_road_finder.sv */
// Associative road finder. A command is taken when start is high and busy is
// low; exactly one result beat follows, shown for one cycle with out_valid,
// and it cannot be held off. After reset the block runs a clearing pass
// (busy high) that loads road r's number into every layer word and clears
// all hit bits. A load, a stub on an unused layer and a read of an empty
// FIFO leave busy low, and the result shows in the next cycle. A read of a
// non-empty FIFO keeps busy high for one cycle while the FIFO memory is
// read. A stub or a detect keeps busy high while a sequencer walks the
// roads one per cycle through a two-stage read/compare/write-back loop over
// the pattern and hit-bit memories. The result shows in the cycle in which
// busy drops, and a new command may be given in that cycle.
module associative_road_finder import arf_pkg::*; #(
  parameter int NUM_ROADS    = 256,
  parameter int NUM_LAYERS   = 6,
  parameter int PATTERN_BITS = 18
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  arf_in_t  in_beat,
  output logic     out_valid,
  output arf_out_t out_beat
);

  localparam int RW = $clog2(NUM_ROADS);
  localparam int LW = $clog2(NUM_LAYERS);
  localparam logic [RW-1:0] LAST_ROAD = RW'(NUM_ROADS - 1);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;

  typedef logic [NUM_LAYERS-1:0][PATTERN_BITS-1:0] row_t;

  // Control state.
  logic [2:0]         state_r, state_nxt;
  logic [RW-1:0]      cnt_r, cnt_nxt;
  logic               p1_v_r, p1_v_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Command payload and scan results.
  logic [RW-1:0]           p1_addr_r, p1_addr_nxt;
  logic                    mode_det_r, mode_det_nxt;
  logic [LW-1:0]           lane_r, lane_nxt;
  logic [PATTERN_BITS-1:0] pat_r, pat_nxt;
  logic [8:0]              found_r, found_nxt;
  logic                    ovf_r, ovf_nxt;
  arf_out_t                out_r, out_nxt;

  // Memory ports.
  logic                  pm_we;
  logic [NUM_LAYERS-1:0] pm_lane_en;
  logic [RW-1:0]         pm_waddr;
  row_t                  pm_wdata;
  row_t                  pm_rdata;
  logic                  hm_we;
  logic [RW-1:0]         hm_waddr;
  logic [NUM_LAYERS-1:0] hm_wdata;
  logic [NUM_LAYERS-1:0] hm_rdata;
  logic                  ff_we;
  logic [FIFO_AW-1:0]    ff_waddr;
  logic [7:0]            ff_wdata;
  logic [7:0]            ff_rdata;

  // Field conversions to the configured widths.
  logic [PATTERN_BITS+17:0]   pat_ext;
  logic [PATTERN_BITS+RW-1:0] clr_ext;
  logic [RW+7:0]              road_ext;
  logic [RW+7:0]              p1_ext;
  logic [PATTERN_BITS-1:0]    in_pat;
  logic [PATTERN_BITS-1:0]    clr_word;
  logic [RW-1:0]              in_road_addr;
  logic [LW-1:0]              in_lane;
  logic [NUM_LAYERS-1:0]      in_lane_oh;
  logic [NUM_LAYERS-1:0]      lane_oh;
  logic                       layer_ok;
  logic                       road_ok;

  assign pat_ext      = {{PATTERN_BITS{1'b0}}, in_beat.pattern};
  assign in_pat       = pat_ext[PATTERN_BITS-1:0];
  assign clr_ext      = {{PATTERN_BITS{1'b0}}, cnt_r};
  assign clr_word     = clr_ext[PATTERN_BITS-1:0];
  assign road_ext     = {{RW{1'b0}}, in_beat.road};
  assign in_road_addr = road_ext[RW-1:0];
  assign p1_ext       = {8'd0, p1_addr_r};
  assign in_lane      = in_beat.layer[LW-1:0];
  assign layer_ok     = ({1'b0, in_beat.layer} < 4'(NUM_LAYERS));
  assign road_ok      = ({5'd0, in_beat.road} < 13'(NUM_ROADS));

  always_comb begin
    in_lane_oh = '0;
    in_lane_oh[in_lane] = 1'b1;
    lane_oh = '0;
    lane_oh[lane_r] = 1'b1;
  end

  // Sequencer and the shared compare / write-back stage.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    p1_v_nxt      = p1_v_r;
    p1_addr_nxt   = p1_addr_r;
    count_nxt     = count_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mode_det_nxt  = mode_det_r;
    lane_nxt      = lane_r;
    pat_nxt       = pat_r;
    found_nxt     = found_r;
    ovf_nxt       = ovf_r;

    pm_we      = 1'b0;
    pm_lane_en = '0;
    pm_waddr   = cnt_r;
    pm_wdata   = {NUM_LAYERS{clr_word}};
    hm_we      = 1'b0;
    hm_waddr   = p1_addr_r;
    hm_wdata   = '0;
    ff_we      = 1'b0;
    ff_waddr   = rd_ptr_r + count_r[FIFO_AW-1:0];
    ff_wdata   = p1_ext[7:0];

    // Second stage: the row read last cycle is compared and written back.
    if (p1_v_r) begin
      if (!mode_det_r) begin
        if (pm_rdata[lane_r] == pat_r) begin
          hm_we    = 1'b1;
          hm_wdata = hm_rdata | lane_oh;
        end
      end else begin
        hm_we = 1'b1;
        if (&hm_rdata) begin
          if (found_r != 9'h1FF) begin
            found_nxt = found_r + 9'd1;
          end
          if (count_r[FIFO_AW]) begin
            ovf_nxt = 1'b1;
          end else begin
            ff_we     = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        pm_we      = 1'b1;
        pm_lane_en = '1;
        hm_we      = 1'b1;
        hm_waddr   = cnt_r;
        if (cnt_r == LAST_ROAD) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          lane_nxt     = in_lane;
          pat_nxt      = in_pat;
          found_nxt    = '0;
          ovf_nxt      = 1'b0;
          mode_det_nxt = (in_beat.command == CMD_DETECT);
          cnt_nxt      = '0;
          out_nxt      = '0;
          out_nxt.fifo_empty = (count_r == '0);
          unique case (in_beat.command)
            CMD_LOAD: begin
              pm_we         = layer_ok && road_ok;
              pm_lane_en    = in_lane_oh;
              pm_waddr      = in_road_addr;
              pm_wdata      = {NUM_LAYERS{in_pat}};
              out_valid_nxt = 1'b1;
            end
            CMD_STUB: begin
              if (layer_ok) begin
                state_nxt = S_SCAN;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            CMD_DETECT: begin
              state_nxt = S_SCAN;
            end
            CMD_READ: begin
              if (count_r != '0) begin
                state_nxt = S_RDWAIT;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        p1_v_nxt    = 1'b1;
        p1_addr_nxt = cnt_r;
        if (cnt_r == LAST_ROAD) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        p1_v_nxt            = 1'b0;
        state_nxt           = S_IDLE;
        out_valid_nxt       = 1'b1;
        out_nxt             = '0;
        out_nxt.roads_found = mode_det_r ? found_nxt : 9'd0;
        out_nxt.overflow    = mode_det_r && ovf_nxt;
        out_nxt.fifo_empty  = (count_nxt == '0);
      end
      S_RDWAIT: begin
        state_nxt          = S_IDLE;
        out_valid_nxt      = 1'b1;
        out_nxt            = '0;
        out_nxt.road_valid = 1'b1;
        out_nxt.road_out   = ff_rdata;
        out_nxt.fifo_empty = (count_r == {{FIFO_AW{1'b0}}, 1'b1});
        rd_ptr_nxt         = rd_ptr_r + 1'b1;
        count_nxt          = count_r - 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      p1_v_r      <= 1'b0;
      count_r     <= '0;
      rd_ptr_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      p1_v_r      <= p1_v_nxt;
      count_r     <= count_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    p1_addr_r  <= p1_addr_nxt;
    mode_det_r <= mode_det_nxt;
    lane_r     <= lane_nxt;
    pat_r      <= pat_nxt;
    found_r    <= found_nxt;
    ovf_r      <= ovf_nxt;
    out_r      <= out_nxt;
  end

  // Memories.
  arf_pattern_mem #(
    .ROWS  (NUM_ROADS),
    .LANES (NUM_LAYERS),
    .WIDTH (PATTERN_BITS)
  ) u_pattern_mem (
    .clk     (clk),
    .we      (pm_we),
    .lane_en (pm_lane_en),
    .waddr   (pm_waddr),
    .wdata   (pm_wdata),
    .raddr   (cnt_r),
    .rdata   (pm_rdata)
  );

  arf_ram #(
    .WIDTH (NUM_LAYERS),
    .DEPTH (NUM_ROADS)
  ) u_hit_mem (
    .clk   (clk),
    .we    (hm_we),
    .waddr (hm_waddr),
    .wdata (hm_wdata),
    .raddr (cnt_r),
    .rdata (hm_rdata)
  );

  arf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_mem (
    .clk   (clk),
    .we    (ff_we),
    .waddr (ff_waddr),
    .wdata (ff_wdata),
    .raddr (rd_ptr_r),
    .rdata (ff_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

/* hdl/arf_ram.sv */
// Simple dual-port RAM: one write port, one read port with registered data.
module arf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/arf_pattern_mem.sv */
// Pattern word store: one row per road, one lane per layer. Lanes are
// written individually (load) or all at once (clearing pass); a read
// returns the whole row through an output register.
module arf_pattern_mem #(
  parameter int ROWS  = 256,
  parameter int LANES = 6,
  parameter int WIDTH = 18,
  localparam int AW = $clog2(ROWS)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [LANES-1:0]            lane_en,
  input  logic [AW-1:0]               waddr,
  input  logic [LANES-1:0][WIDTH-1:0] wdata,
  input  logic [AW-1:0]               raddr,
  output logic [LANES-1:0][WIDTH-1:0] rdata
);

  logic [LANES-1:0][WIDTH-1:0] mem [ROWS];
  logic [LANES-1:0][WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      if (we && lane_en[l]) begin
        mem[waddr][l] <= wdata[l];
      end
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hdl/arf_checker.sv */
// Port-level checks for the road finder.
module arf_checker import arf_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input arf_out_t out_beat
);

  // The clearing pass holds the block busy right after reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> busy)
    else $error("block not busy during the clearing pass");

  // An accepted command either answers in the next cycle or keeps busy high.
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither answered nor busy");

  // A result beat always comes with the block ready for the next command.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while still busy");

  // A popped road never carries detect statistics.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.road_valid) |->
      (out_beat.roads_found == 9'd0 && !out_beat.overflow))
    else $error("read result carries detect fields");

  // Roads are dropped only when the FIFO is full, so it cannot be empty.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.overflow) |-> !out_beat.fifo_empty)
    else $error("overflow reported with an empty FIFO");

endmodule

bind associative_road_finder arf_checker u_arf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_beat  (out_beat)
);
